// File: design/fpst_pkg.sv
`default_nettype none

package fpst_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = 13;
  localparam int NODE_W      = POS_W + 1;   // climb may step past the last node
  localparam int DELTA_W     = 32;
  localparam int SUM_W       = 64;

  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(4096);
  localparam logic [POS_W-1:0] DEPTH_POS  = POS_W'(TABLE_DEPTH);

  // func field codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// File: design/fpst_ram.sv
`default_nettype none

module fpst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/fpst_ctrl.sv
`default_nettype none

module fpst_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic        [fpst_pkg::POS_W-1:0]   position,
  input  wire logic signed [fpst_pkg::DELTA_W-1:0] delta,
  input  wire logic        [fpst_pkg::POS_W-1:0]   lim,
  output fpst_pkg::mem_req_t                     mem_req,
  input  wire logic        [fpst_pkg::SUM_W-1:0]   rdata,
  output logic                                   done,
  output logic signed      [fpst_pkg::SUM_W-1:0]   prefix_sum
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                              state;
  logic [fpst_pkg::ADDR_W-1:0]         clr_addr;
  logic [fpst_pkg::NODE_W-1:0]         k;
  logic                                is_query;
  logic [fpst_pkg::DELTA_W-1:0]        delta_r;
  logic [fpst_pkg::SUM_W-1:0]          acc;

  logic [fpst_pkg::NODE_W-1:0]         lim_n;
  logic [fpst_pkg::NODE_W-1:0]         k0;
  logic                                k0_live;
  logic [fpst_pkg::NODE_W-1:0]         low_bit;
  logic [fpst_pkg::NODE_W-1:0]         k_step;
  logic                                walk_more;
  logic [fpst_pkg::NODE_W-1:0]         k_m1;
  logic [fpst_pkg::NODE_W-1:0]         k0_m1;
  logic [fpst_pkg::NODE_W-1:0]         k_step_m1;
  logic [fpst_pkg::SUM_W-1:0]          delta_ext;
  logic [fpst_pkg::SUM_W-1:0]          acc_sum;

  assign busy = (state != ST_IDLE);

  always_comb begin
    lim_n     = {1'b0, lim};
    delta_ext = {{(fpst_pkg::SUM_W - fpst_pkg::DELTA_W){delta_r[fpst_pkg::DELTA_W-1]}},
                 delta_r};
    acc_sum   = acc + rdata;

    // first node of the walk
    if (func == fpst_pkg::FUNC_QUERY) begin
      k0      = (position > lim) ? lim_n : {1'b0, position};
      k0_live = (k0 != '0);
    end else begin
      k0      = {1'b0, position} + fpst_pkg::NODE_W'(1);
      k0_live = (position < lim);
    end

    low_bit = k & (~k + fpst_pkg::NODE_W'(1));
    if (is_query) begin
      k_step    = k - low_bit;
      walk_more = (k_step != '0);
    end else begin
      k_step    = k + low_bit;
      walk_more = (k_step <= lim_n);
    end

    k_m1      = k - fpst_pkg::NODE_W'(1);
    k0_m1     = k0 - fpst_pkg::NODE_W'(1);
    k_step_m1 = k_step - fpst_pkg::NODE_W'(1);

    mem_req = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
      end
      ST_IDLE: begin
        mem_req.raddr = k0_m1[fpst_pkg::ADDR_W-1:0];
      end
      ST_WALK: begin
        // write back node k, read the next node of the chain in the same cycle
        mem_req.we    = !is_query;
        mem_req.waddr = k_m1[fpst_pkg::ADDR_W-1:0];
        mem_req.wdata = rdata + delta_ext;
        mem_req.raddr = k_step_m1[fpst_pkg::ADDR_W-1:0];
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + fpst_pkg::ADDR_W'(1);
          if (clr_addr == fpst_pkg::ADDR_W'(fpst_pkg::TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            is_query <= (func == fpst_pkg::FUNC_QUERY);
            delta_r  <= delta;
            acc      <= '0;
            k        <= k0;
            if (k0_live) begin
              state <= ST_WALK;
            end else if (func == fpst_pkg::FUNC_QUERY) begin
              done       <= 1'b1;
              prefix_sum <= '0;
            end
          end
        end
        ST_WALK: begin
          acc <= acc_sum;
          k   <= k_step;
          if (!walk_more) begin
            state <= ST_IDLE;
            if (is_query) begin
              done       <= 1'b1;
              prefix_sum <= acc_sum;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only follows the last step of a query walk or an empty query
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_WALK && $past(is_query))
             || ($past(state) == ST_IDLE && $past(start)))
    else $error("result strobe without a finished query");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_req.we)
    else $error("memory write while idle");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (mem_req.we && mem_req.wdata == '0))
    else $error("clearing pass writes nonzero data");

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && mem_req.we && walk_more) |-> (mem_req.waddr != mem_req.raddr))
    else $error("next read hits the node being written");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && is_query) |-> !mem_req.we)
    else $error("query walk writes memory");

endmodule

`default_nettype wire

// File: design/fenwick_prefix_sum_table_core.sv
`default_nettype none

// Channel    Signals                              Transfer
// ---------  -----------------------------------  ----------------------------------
// item in    start, busy, func, position, delta   edge with start high and busy low
// result     done, prefix_sum                     edge ending the cycle done is high
// size reg   size_we, size_in_use                 edge with size_we high
//
// After reset busy stays high while the node store is cleared, one entry a
// cycle; size writes are taken during that pass.
// An item walks the nodes on its chain (at most 13 for 4096 nodes): one
// memory read per node, the write-back of a node overlapping the read of the
// next one through the single read and write port.
// An add outside the size and a query that clamps to zero end without a walk.
// A query result shows on done/prefix_sum for one cycle after its last node;
// the receiver cannot stall it. Adds produce no result.

module fenwick_prefix_sum_table_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  func,
  input  wire logic        [fpst_pkg::POS_W-1:0]     position,
  input  wire logic signed [fpst_pkg::DELTA_W-1:0]   delta,
  output logic                                       done,
  output logic signed      [fpst_pkg::SUM_W-1:0]     prefix_sum,
  input  wire logic                                  size_we,
  input  wire logic        [fpst_pkg::POS_W-1:0]     size_in_use
);

  // Size register: hold the written value, cap it at the table depth.
  logic [fpst_pkg::POS_W-1:0] size_r;
  logic [fpst_pkg::POS_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_r <= fpst_pkg::SIZE_RESET;
    end else if (size_we) begin
      size_r <= size_in_use;
    end
  end

  assign lim = (size_r > fpst_pkg::DEPTH_POS) ? fpst_pkg::DEPTH_POS : size_r;

  // Node store: entry k-1 holds node k of the tree.
  fpst_pkg::mem_req_t          mem_req;
  logic [fpst_pkg::SUM_W-1:0]  rdata;

  fpst_ram #(
    .WIDTH (fpst_pkg::SUM_W),
    .DEPTH (fpst_pkg::TABLE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // Walk sequencer: clear pass, climb for adds, descent for queries.
  fpst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .position   (position),
    .delta      (delta),
    .lim        (lim),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .done       (done),
    .prefix_sum (prefix_sum)
  );

endmodule

`default_nettype wire
